// File: hdl/double_ended_queue_macros.svh
// Assertion macros for the double-ended queue.
// Used by the top level; no other dependencies.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

`ifndef SYNTHESIS
`define DQ_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
`define DQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define DQ_ASSERT_IMPL(label, clk, rst, ante, cons)
`define DQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: hdl/dq_pkg.sv
// Shared types and codes for the double-ended queue.
// No dependencies; imported by every module of the block.
package dq_pkg;

   localparam int DATA_W          = 32;
   localparam int OP_W            = 3;
   localparam int STAT_W          = 2;
   localparam int DQ_DEPTH_DEF    = 64;
   localparam int RSP_FIFO_DEPTH  = 4;
   localparam int RSP_PTR_W       = $clog2(RSP_FIFO_DEPTH);
   localparam int RSP_LVL_W       = $clog2(RSP_FIFO_DEPTH + 1);

   // operation codes
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd3;
   localparam logic [OP_W-1:0] OP_DUMP       = 3'd4;

   // status codes
   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

   typedef struct packed {
      logic [STAT_W-1:0]        status;
      logic signed [DATA_W-1:0] item;
      logic                     last;
   } rsp_beat_type;

   typedef struct packed {
      logic         valid;
      rsp_beat_type beat;
   } rsp_push_type;

endpackage

// File: hdl/dq_ram.sv
// Ring store of the queue: one write port, one read port, registered read data.
// Depends on dq_pkg.
module dq_ram
   import dq_pkg::*;
#(
   parameter int DEPTH = DQ_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic signed [DATA_W-1:0]   wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic signed [DATA_W-1:0]   rd_data
);

   logic signed [DATA_W-1:0] mem [DEPTH];
   logic signed [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/dq_rsp_fifo.sv
// Small result FIFO that decouples the control from the result channel.
// Depends on dq_pkg.
module dq_rsp_fifo
   import dq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  rsp_push_type           push,
   output logic [RSP_LVL_W-1:0]   level,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [DATA_W-1:0]      rsp_tdata,   // [31:0] item
   output logic [STAT_W-1:0]      rsp_tuser,   // [1:0] status
   output logic                   rsp_tlast
);

   rsp_beat_type            buf_ff [RSP_FIFO_DEPTH];
   logic [RSP_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [RSP_LVL_W-1:0]    level_ff, level_in;
   logic                    pop;

   assign rsp_tvalid = (level_ff != '0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = buf_ff[rd_ptr_ff].item;
   assign rsp_tuser  = buf_ff[rd_ptr_ff].status;
   assign rsp_tlast  = buf_ff[rd_ptr_ff].last;
   assign level      = level_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push.valid) begin
         wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(1);
      end
      if (push.valid && !pop) begin
         level_in = level_ff + RSP_LVL_W'(1);
      end else if (!push.valid && pop) begin
         level_in = level_ff - RSP_LVL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         buf_ff[wr_ptr_ff] <= push.beat;
      end
   end

endmodule

// File: hdl/double_ended_queue.sv
// Bounded double-ended queue of signed 32-bit values held in a single-port-write,
// registered-read ring RAM of DEPTH entries, tracked by a head index and a fill
// count. Push front/rear and pop front/rear give one status beat each (ok, empty
// on a pop of an empty queue, full on a push to a full queue); codes 5 to 7 are
// absorbed with no result. A dump streams every stored value front to rear, one
// RAM read per cycle while the result FIFO has room, tlast on the final one: it
// holds req_tready low until the last read data has landed in the FIFO (an empty
// dump gives a single empty beat). Results pass through a four-beat FIFO, so the
// request side keeps moving while the result side stalls, until that FIFO fills.
// The RAM needs no clearing pass after reset; only written entries are ever read.
// Depends on dq_pkg, dq_ram, dq_rsp_fifo and double_ended_queue_macros.svh.
`include "double_ended_queue_macros.svh"

module double_ended_queue
   import dq_pkg::*;
#(
   parameter int DEPTH = DQ_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [DATA_W-1:0]   req_tdata,   // [31:0] value
   input  logic [OP_W-1:0]     req_tuser,   // [2:0] operation
   // result channel
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [DATA_W-1:0]   rsp_tdata,   // [31:0] item
   output logic [STAT_W-1:0]   rsp_tuser,   // [1:0] status
   output logic                rsp_tlast    // last beat caused by this request
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   // control states
   localparam logic S_IDLE = 1'b0;
   localparam logic S_DUMP = 1'b1;

   logic                   state_ff, state_in;
   logic [IDX_W-1:0]       head_ff, head_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [IDX_W-1:0]       dump_addr_ff, dump_addr_in;
   logic [CNT_W-1:0]       dump_left_ff, dump_left_in;
   logic                   rd_pend_ff, rd_pend_in;     // RAM read data lands this cycle
   logic                   pend_last_ff, pend_last_in;

   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic                   rd_en;
   logic signed [DATA_W-1:0] rd_data;

   rsp_push_type           rsp_push;
   logic [RSP_LVL_W-1:0]   rsp_level;
   logic                   room;
   logic                   req_acc;
   logic                   full;
   logic                   empty;
   logic [IDX_W-1:0]       head_inc;
   logic [IDX_W-1:0]       head_dec;
   logic [IDX_W-1:0]       dump_inc;
   logic [SUM_W-1:0]       rear_sum;
   logic [IDX_W-1:0]       rear_addr;

   // FIFO space counts the read already in flight
   assign room       = (rsp_level + RSP_LVL_W'(rd_pend_ff)) < RSP_LVL_W'(RSP_FIFO_DEPTH);
   assign req_tready = (state_ff == S_IDLE) && !rd_pend_ff && room;
   assign req_acc    = req_tvalid && req_tready;

   assign full  = (cnt_ff == CNT_W'(DEPTH));
   assign empty = (cnt_ff == '0);

   // modulo-DEPTH index arithmetic
   assign head_inc  = (head_ff == IDX_W'(DEPTH - 1)) ? '0 : head_ff + IDX_W'(1);
   assign head_dec  = (head_ff == '0) ? IDX_W'(DEPTH - 1) : head_ff - IDX_W'(1);
   assign dump_inc  = (dump_addr_ff == IDX_W'(DEPTH - 1)) ? '0 : dump_addr_ff + IDX_W'(1);
   assign rear_sum  = SUM_W'(head_ff) + SUM_W'(cnt_ff);
   assign rear_addr = (rear_sum >= SUM_W'(DEPTH)) ? IDX_W'(rear_sum - SUM_W'(DEPTH))
                                                  : IDX_W'(rear_sum);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      cnt_in        = cnt_ff;
      dump_addr_in  = dump_addr_ff;
      dump_left_in  = dump_left_ff;
      rd_pend_in    = 1'b0;
      pend_last_in  = pend_last_ff;
      wr_en         = 1'b0;
      wr_addr       = rear_addr;
      rd_en         = 1'b0;
      rsp_push.valid       = 1'b0;
      rsp_push.beat.status = STAT_OK;
      rsp_push.beat.item   = '0;
      rsp_push.beat.last   = 1'b1;

      // dump data coming back from the RAM
      if (rd_pend_ff) begin
         rsp_push.valid       = 1'b1;
         rsp_push.beat.status = STAT_OK;
         rsp_push.beat.item   = rd_data;
         rsp_push.beat.last   = pend_last_ff;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               unique case (req_tuser)
                  OP_PUSH_FRONT: begin
                     rsp_push.valid = 1'b1;
                     if (full) begin
                        rsp_push.beat.status = STAT_FULL;
                     end else begin
                        head_in = head_dec;
                        wr_en   = 1'b1;
                        wr_addr = head_dec;
                        cnt_in  = cnt_ff + CNT_W'(1);
                     end
                  end
                  OP_PUSH_REAR: begin
                     rsp_push.valid = 1'b1;
                     if (full) begin
                        rsp_push.beat.status = STAT_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = rear_addr;
                        cnt_in  = cnt_ff + CNT_W'(1);
                     end
                  end
                  OP_POP_FRONT: begin
                     rsp_push.valid = 1'b1;
                     if (empty) begin
                        rsp_push.beat.status = STAT_EMPTY;
                     end else begin
                        head_in = head_inc;
                        cnt_in  = cnt_ff - CNT_W'(1);
                     end
                  end
                  OP_POP_REAR: begin
                     rsp_push.valid = 1'b1;
                     if (empty) begin
                        rsp_push.beat.status = STAT_EMPTY;
                     end else begin
                        cnt_in = cnt_ff - CNT_W'(1);
                     end
                  end
                  OP_DUMP: begin
                     if (empty) begin
                        rsp_push.valid       = 1'b1;
                        rsp_push.beat.status = STAT_EMPTY;
                     end else begin
                        state_in     = S_DUMP;
                        dump_addr_in = head_ff;
                        dump_left_in = cnt_ff;
                     end
                  end
                  default: begin
                     // unknown code: dropped silently
                  end
               endcase
            end
         end
         S_DUMP: begin
            if (room) begin
               rd_en        = 1'b1;
               rd_pend_in   = 1'b1;
               pend_last_in = (dump_left_ff == CNT_W'(1));
               dump_addr_in = dump_inc;
               dump_left_in = dump_left_ff - CNT_W'(1);
               if (dump_left_ff == CNT_W'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         head_ff    <= '0;
         cnt_ff     <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         head_ff    <= head_in;
         cnt_ff     <= cnt_in;
         rd_pend_ff <= rd_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      dump_addr_ff <= dump_addr_in;
      dump_left_ff <= dump_left_in;
      pend_last_ff <= pend_last_in;
   end

   dq_ram #(
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (signed'(req_tdata)),
      .rd_en   (rd_en),
      .rd_addr (dump_addr_ff),
      .rd_data (rd_data)
   );

   dq_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (rsp_push),
      .level      (rsp_level),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // fill count never passes the bound
   `DQ_ASSERT_IMPL(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CNT_W'(DEPTH))
   // a request is never taken while dump data is landing (one FIFO write port)
   `DQ_ASSERT_IMPL(a_no_double_enq, clock, reset, rd_pend_ff, !req_acc)
   // queue contents are frozen for the length of a dump
   `DQ_ASSERT_NEXT(a_dump_frozen, clock, reset, state_ff == S_DUMP, cnt_ff == $past(cnt_ff))
   // an accepted push into a non-full queue grows it by one
   `DQ_ASSERT_NEXT(a_push_grows, clock, reset,
      req_acc && !full && (req_tuser == OP_PUSH_FRONT || req_tuser == OP_PUSH_REAR),
      cnt_ff == $past(cnt_ff) + CNT_W'(1))

endmodule
